/* rtl/nfsa_pkg.sv */
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared constants and types for the next-fit slot allocator.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int ALU_W      = CNT_W + 1;

    localparam logic [CNT_W-1:0] POOL_SIZE_RST = CNT_W'(POOL_SLOTS);
    localparam logic [CNT_W-1:0] POOL_MAX      = CNT_W'(POOL_SLOTS);

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_POOL_SIZE = 1'b0;

    typedef struct packed {
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] idx;
    } tbl_upd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] last;
        logic              any;
        logic              hit;
    } tbl_stat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   granted;
        logic [CNT_W-1:0]    in_use;
    } result_t;

endpackage

/* rtl/nfsa_slot_tbl.sv */
// ----------------------------------------------------------------------------
// nfsa_slot_tbl
// Slot active flags, active count, last granted slot and first-grant flag.
// ----------------------------------------------------------------------------
module nfsa_slot_tbl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  nfsa_pkg::tbl_upd_t          upd,
    input  logic [nfsa_pkg::SLOT_W-1:0] rd_idx,
    output logic                        ready,
    output nfsa_pkg::tbl_stat_t         stat
);
    import nfsa_pkg::*;

    logic                  active_mem [POOL_SLOTS];
    logic                  hit_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SLOT_W-1:0]     last_reg;
    logic                  any_reg;
    logic                  clr_busy_reg;
    logic [SLOT_W-1:0]     clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            active_mem[clr_idx_reg] <= 1'b0;
        end else if (upd.set) begin
            active_mem[upd.idx] <= 1'b1;
        end else if (upd.clr) begin
            active_mem[upd.idx] <= 1'b0;
        end
        hit_reg <= active_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            count_reg    <= '0;
            last_reg     <= '0;
            any_reg      <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
                if (clr_idx_reg == SLOT_W'(POOL_SLOTS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (upd.set) begin
                count_reg <= count_reg + CNT_W'(1);
                last_reg  <= upd.idx;
                any_reg   <= 1'b1;
            end else if (upd.clr && hit_reg) begin
                if (count_reg != '0) begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
        end
    end

    assign ready      = !clr_busy_reg;
    assign stat.count = count_reg;
    assign stat.last  = last_reg;
    assign stat.any   = any_reg;
    assign stat.hit   = hit_reg;

endmodule

/* rtl/nfsa_ctrl.sv */
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Request sequencer: start-point reduction and next-fit scan on one shared
// adder, then commit of the table update together with the result.
// ----------------------------------------------------------------------------
module nfsa_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req,
    input  logic                        opcode,
    input  logic [nfsa_pkg::SLOT_W-1:0] slot_to_free,
    input  logic [nfsa_pkg::CNT_W-1:0]  size,
    input  logic                        out_free,
    input  nfsa_pkg::tbl_stat_t         stat,
    output logic                        idle,
    output logic [nfsa_pkg::SLOT_W-1:0] rd_idx,
    output nfsa_pkg::tbl_upd_t          upd,
    output logic                        res_load,
    output nfsa_pkg::result_t           res
);
    import nfsa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_REDUCE, S_READ, S_SCAN, S_DONE} state_t;

    state_t               state_reg, state_next;
    logic                 op_reg, op_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic [ALU_W-1:0]     alu_a, alu_b, alu_sum;
    logic                 wrap;
    logic                 done_ok;

    // shared adder: pos - size while reducing, pos + 1 while scanning
    assign alu_a   = {1'b0, pos_reg};
    assign alu_b   = (state_reg == S_REDUCE) ? (~{1'b0, size} + ALU_W'(1)) : ALU_W'(1);
    assign alu_sum = alu_a + alu_b;
    assign wrap    = (alu_sum[CNT_W-1:0] == size);

    assign idle    = (state_reg == S_IDLE);
    assign rd_idx  = pos_reg[SLOT_W-1:0];
    assign done_ok = (state_reg == S_DONE) && (status_reg == ST_OK);

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req) begin
                    op_next = opcode;
                    n_next  = '0;
                    if (opcode == OP_FREE) begin
                        pos_next = {1'b0, slot_to_free};
                        if ({1'b0, slot_to_free} >= size) begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end else begin
                            status_next = ST_OK;
                            state_next  = S_READ;
                        end
                    end else if (size == '0 || stat.count >= size) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        pos_next    = stat.any ? ({1'b0, stat.last} + CNT_W'(1)) : '0;
                        status_next = ST_OK;
                        state_next  = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (!alu_sum[ALU_W-1]) begin
                    pos_next = alu_sum[CNT_W-1:0];
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = (op_reg == OP_FREE) ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (!stat.hit) begin
                    state_next = S_DONE;
                end else if ((n_reg + CNT_W'(1)) == size) begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    pos_next   = wrap ? '0 : alu_sum[CNT_W-1:0];
                    n_next     = n_reg + CNT_W'(1);
                    state_next = S_READ;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_ALLOC;
            pos_reg    <= '0;
            n_reg      <= '0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            pos_reg    <= pos_next;
            n_reg      <= n_next;
            status_reg <= status_next;
        end
    end

    assign res_load = (state_reg == S_DONE) && out_free;

    assign upd.set = res_load && done_ok && (op_reg == OP_ALLOC);
    assign upd.clr = res_load && done_ok && (op_reg == OP_FREE);
    assign upd.idx = pos_reg[SLOT_W-1:0];

    always_comb begin
        res.status  = status_reg;
        res.granted = '0;
        res.in_use  = stat.count;
        if (done_ok && op_reg == OP_ALLOC) begin
            res.granted = pos_reg[SLOT_W-1:0];
            res.in_use  = stat.count + CNT_W'(1);
        end else if (done_ok && stat.hit && stat.count != '0) begin
            res.in_use  = stat.count - CNT_W'(1);
        end
    end

endmodule

/* rtl/next_fit_slot_allocator_top.sv */
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_top
// Next-fit slot allocator over a pool of 64 slots with a configurable size.
//
//   Port group   Dir   Contents
//   s_*          in    request: tuser opcode, tdata slot_to_free
//   m_*          out   result: tuser status, tdata granted_slot, slots_in_use
//   APB          in    register 0 pool_size at byte address 0
//
// From accept, an out-of-pool free or an allocate on a full count goes straight
// to the result; a free reads its slot flag first. An allocate runs R start/size
// subtract steps on the shared adder, then S <= size slot probes, each a flag
// read and a test, before its result.
// s_tready is high only while the sequencer is idle; a result waiting in the
// output register holds the commit of the following request.
// After reset the slot flags clear one per cycle; s_tready stays low until all 64 are clear.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] slot_to_free, [7:6] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] granted_slot, [12:6] slots_in_use, [15:13] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nfsa_pkg::*;

    logic [CNT_W-1:0]  pool_size_reg;
    logic [CNT_W-1:0]  size;
    logic              m_tvalid_reg;
    result_t           res_reg;
    logic              out_free;
    logic              idle;
    logic              tbl_ready;
    logic [SLOT_W-1:0] rd_idx;
    tbl_upd_t          upd;
    tbl_stat_t         stat;
    logic              res_load;
    result_t           res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POOL_SIZE) ? {25'd0, pool_size_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg <= POOL_SIZE_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_POOL_SIZE) begin
            pool_size_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign size = (pool_size_reg > POOL_MAX) ? POOL_MAX : pool_size_reg;

    assign s_tready = idle && tbl_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    nfsa_slot_tbl u_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .rd_idx  (rd_idx),
        .ready   (tbl_ready),
        .stat    (stat)
    );

    nfsa_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (s_tvalid && s_tready),
        .opcode       (s_tuser[0]),
        .slot_to_free (s_tdata[SLOT_W-1:0]),
        .size         (size),
        .out_free     (out_free),
        .stat         (stat),
        .idle         (idle),
        .rd_idx       (rd_idx),
        .upd          (upd),
        .res_load     (res_load),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {3'd0, res_reg.in_use, res_reg.granted};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= POOL_MAX)
        else $error("active count above pool slots");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    a_grant_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[SLOT_W-1:0] == '0))
        else $error("slot granted on failed request");

    a_no_commit_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        idle |-> (!upd.set && !upd.clr && !res_load))
        else $error("table update while idle");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the next-fit slot allocator. Requests enter on the
// s_ stream in random bursts while the m_ side stalls on its own pattern. A
// scoreboard mirrors the slot flags, the count and the last grant, predicts
// each reply, and compares it field by field. The pool size is rewritten over
// APB between phases: zero, one, the full pool, oversize values and small
// random sizes, including shrinks below slots that are still held.
// ----------------------------------------------------------------------------
module tb;
    import nfsa_pkg::*;

    class slot_grant_scoreboard;
        bit               slot_on [POOL_SLOTS];
        bit [CNT_W-1:0]   in_use        = '0;
        bit [SLOT_W-1:0]  last_slot     = '0;
        bit               granted_once  = 1'b0;
        bit [CNT_W-1:0]   pool_size     = POOL_SIZE_RST;
        result_t          pending_replies [$];
        int               errors        = 0;

        function int eff_size();
            return (pool_size > POOL_SLOTS) ? POOL_SLOTS : int'(pool_size);
        endfunction

        function void set_pool_size(bit [CNT_W-1:0] value);
            pool_size = value;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function logic [SLOT_W-1:0] pick_busy();
            int size;
            int busy [$];
            size = eff_size();
            for (int i = 0; i < size; i++)
                if (slot_on[i]) busy.push_back(i);
            if (busy.size() == 0) return SLOT_W'($urandom_range(POOL_SLOTS - 1));
            return SLOT_W'(busy[$urandom_range(busy.size() - 1)]);
        endfunction

        function void note_request(logic op, logic [SLOT_W-1:0] idx);
            int      size;
            int      pos;
            int      n;
            bit      found;
            result_t r;
            size      = eff_size();
            r.status  = ST_OK;
            r.granted = '0;
            if (op == OP_ALLOC) begin
                if (size == 0 || int'(in_use) >= size) begin
                    r.status = ST_FULL;
                end else begin
                    pos   = granted_once ? (int'(last_slot) + 1) % size : 0;
                    found = 1'b0;
                    for (n = 0; n < size && !found; n++) begin
                        if (!slot_on[pos]) found = 1'b1;
                        else pos = (pos + 1) % size;
                    end
                    if (found) begin
                        slot_on[pos]  = 1'b1;
                        in_use        = in_use + 1'b1;
                        last_slot     = SLOT_W'(pos);
                        granted_once  = 1'b1;
                        r.granted     = SLOT_W'(pos);
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end else begin
                if (int'(idx) >= size) begin
                    r.status = ST_RANGE;
                end else if (slot_on[idx]) begin
                    slot_on[idx] = 1'b0;
                    if (in_use > 0) in_use = in_use - 1'b1;
                end
            end
            r.in_use = in_use;
            pending_replies.push_back(r);
        endfunction

        function void check_reply(result_t got);
            result_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with no request pending: status %0d slot %0d count %0d",
                         $time, got.status, got.granted, got.in_use);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.granted !== want.granted) begin
                $display("%0t: granted_slot expected %0d got %0d",
                         $time, want.granted, got.granted);
                errors++;
            end
            if (got.in_use !== want.in_use) begin
                $display("%0t: slots_in_use expected %0d got %0d",
                         $time, want.in_use, got.in_use);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [5:0] slot_to_free, [7:6] zero
    logic [0:0]  s_tuser;    // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [5:0] granted_slot, [12:6] slots_in_use, [15:13] zero
    logic [1:0]  m_tuser;    // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slot_grant_scoreboard sb;
    int stall_pct  = 0;
    int gap_max    = 0;
    int burst_left = 0;

    next_fit_slot_allocator_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tuser[0], s_tdata[SLOT_W-1:0]);
            if (m_tvalid && m_tready) begin
                got.status  = m_tuser;
                got.granted = m_tdata[SLOT_W-1:0];
                got.in_use  = m_tdata[SLOT_W+CNT_W-1:SLOT_W];
                sb.check_reply(got);
            end
        end
    end

    task automatic send_request(input logic op, input logic [SLOT_W-1:0] idx);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(gap_max, 1) - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(16, 1);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain(input int settle);
        @(negedge aclk);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_pool_size(input logic [CNT_W-1:0] value);
        drain(8);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(REG_POOL_SIZE));
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_pool_size(value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int          sent;
        int          len;
        int          alloc_pct;
        int          pick;
        logic [CNT_W-1:0] size;
        logic [SLOT_W-1:0] idx;

        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full pool from reset: first grant, free of held and idle slots
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_ALLOC, 6'd63);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_FREE, 6'd1);
        send_request(OP_FREE, 6'd1);
        send_request(OP_FREE, 6'd63);
        send_request(OP_ALLOC, 6'd0);

        // shrink below held slots and the last grant
        write_pool_size(7'd2);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_FREE, 6'd2);
        send_request(OP_FREE, 6'd0);
        send_request(OP_ALLOC, 6'd0);

        write_pool_size(7'd0);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_FREE, 6'd0);

        // oversize clamps to the built pool
        write_pool_size(7'd127);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_FREE, 6'd63);
        send_request(OP_FREE, 6'd3);
        send_request(OP_FREE, 6'd2);
        send_request(OP_FREE, 6'd4);
        send_request(OP_FREE, 6'd1);

        write_pool_size(7'd1);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_ALLOC, 6'd0);
        send_request(OP_FREE, 6'd0);
        send_request(OP_ALLOC, 6'd0);

        sent = 0;
        while (sent < 1950) begin
            pick = $urandom_range(9);
            case (pick)
                0: size = 7'd1;
                1: size = 7'd64;
                2: size = 7'd0;
                3: size = 7'($urandom_range(127, 65));
                4: size = 7'($urandom_range(63, 17));
                default: size = 7'($urandom_range(16, 2));
            endcase
            write_pool_size(size);
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(70, 5);
            gap_max   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            alloc_pct = $urandom_range(85, 20);
            len       = (size == 0) ? $urandom_range(20, 5) : $urandom_range(160, 40);
            if (len > 1950 - sent) len = 1950 - sent;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(99) < alloc_pct) begin
                    send_request(OP_ALLOC, SLOT_W'($urandom_range(63)));
                end else begin
                    idx = ($urandom_range(99) < 80) ? sb.pick_busy()
                                                    : SLOT_W'($urandom_range(63));
                    send_request(OP_FREE, idx);
                end
                sent++;
            end
        end

        drain(150);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
